// ===== sv/nvis_pkg.sv =====
// shared types and codes for the nearest value index search block
`default_nettype none
package nvis_pkg;

	localparam int KeyWidth = 32;
	localparam int IdxWidth = 14;
	localparam int LenWidth = 15;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                        kind;
		logic [IdxWidth-1:0]         element_index;
		logic signed [KeyWidth-1:0]  item_value;
		logic                        final_query;
	} nvis_in_t;

	typedef struct packed {
		logic [IdxWidth-1:0] nearest_index;
		logic                batch_last;
	} nvis_out_t;

	typedef enum logic [1:0] {
		RD_PROBE = 2'd0,
		RD_MID   = 2'd1,
		RD_HI    = 2'd2,
		RD_BELOW = 2'd3
	} nvis_rd_sel_t;

	typedef enum logic [1:0] {
		BS_HOLD  = 2'd0,
		BS_PROBE = 2'd1,
		BS_ZERO  = 2'd2,
		BS_STEP  = 2'd3
	} nvis_bs_op_t;

	typedef enum logic [1:0] {
		RES_HOLD = 2'd0,
		RES_ZERO = 2'd1,
		RES_HI   = 2'd2,
		RES_R    = 2'd3
	} nvis_res_sel_t;

	typedef struct packed {
		logic          accept;
		logic          probe_init;
		logic          probe_dbl;
		logic          rd_en;
		nvis_rd_sel_t  rd_sel;
		nvis_bs_op_t   bs_op;
		logic          r_cap;
		logic          vr_cap;
		nvis_res_sel_t res_sel;
		logic          out_load;
	} nvis_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic probe_lt_n;
		logic elem_lt_tgt;
		logic lo_lt_hi;
		logic r_nz;
		logic low_wins;
		logic out_busy;
	} nvis_sts_t;

endpackage
`default_nettype wire

// ===== sv/nearest_value_index_search.sv =====
// top level of the nearest value index search block
// in channel: in_valid/in_stall with an nvis_in_t beat. kind load writes item_value
// into the store at element_index (indices past the store are dropped).
// kind query searches for the lowest index of the element nearest item_value.
// out channel: out_valid/out_stall with an nvis_out_t beat, one per query.
// cfg channel: cfg_valid/cfg_ready writes array_length (saturated to STORE_DEPTH);
// cfg_ready is always high, write it only while no query is in flight.
// a query reads the store through the single registered read port, once per probe
// doubling, per binary search step, for the split element and for its lower neighbor,
// then loads the result into the output register; an empty array reads nothing.
// in_stall is high from query accept until its result enters the output register.
// when out_stall holds the output register full, a finished query waits there and
// no new beat is taken; loads and the next query pass once the register frees.
// reset clears the controller, array_length and the output valid; store contents
// are undefined until written.
`default_nettype none
module nearest_value_index_search #(
	parameter int STORE_DEPTH = 16384,
	parameter int VALUE_WIDTH = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  nvis_pkg::nvis_in_t            in_data,
	output logic                          out_valid,
	input  wire                           out_stall,
	output nvis_pkg::nvis_out_t           out_data,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [nvis_pkg::LenWidth-1:0] cfg_data
);
	import nvis_pkg::*;

	nvis_cmd_t cmd;
	nvis_sts_t sts;

	assign cfg_ready = 1'b1;

	nvis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	nvis_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== sv/nvis_ctrl.sv =====
// sequencer for the probe doubling and binary search passes
`default_nettype none
module nvis_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_kind,
	output logic                in_stall,
	input  nvis_pkg::nvis_sts_t sts,
	output nvis_pkg::nvis_cmd_t cmd
);
	import nvis_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_PROBE_RD  = 8'b0000_0010,
		ST_PROBE_CHK = 8'b0000_0100,
		ST_BS_RD     = 8'b0000_1000,
		ST_BS_CHK    = 8'b0001_0000,
		ST_R_CHK     = 8'b0010_0000,
		ST_BELOW_CHK = 8'b0100_0000,
		ST_FIN       = 8'b1000_0000
	} nvis_state_t;

	nvis_state_t st_q, st_d;
	logic        second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		cmd      = '0;
		st_d     = st_q;
		second_d = second_q;
		in_stall = 1'b1;
		case (st_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_kind == KIND_QUERY) begin
						second_d = 1'b0;
						if (sts.n_zero) begin
							cmd.res_sel = RES_ZERO;
							st_d        = ST_FIN;
						end else begin
							cmd.probe_init = 1'b1;
							st_d           = ST_PROBE_RD;
						end
					end
				end
			end
			ST_PROBE_RD: begin
				if (sts.probe_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PROBE;
					st_d       = ST_PROBE_CHK;
				end else begin
					cmd.bs_op = BS_PROBE;
					st_d      = ST_BS_RD;
				end
			end
			ST_PROBE_CHK: begin
				if (sts.elem_lt_tgt) begin
					cmd.probe_dbl = 1'b1;
					st_d          = ST_PROBE_RD;
				end else begin
					cmd.bs_op = BS_PROBE;
					st_d      = ST_BS_RD;
				end
			end
			ST_BS_RD: begin
				if (sts.lo_lt_hi) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_MID;
					st_d       = ST_BS_CHK;
				end else if (second_q) begin
					cmd.res_sel = RES_HI;
					st_d        = ST_FIN;
				end else begin
					cmd.r_cap  = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_HI;
					st_d       = ST_R_CHK;
				end
			end
			ST_BS_CHK: begin
				cmd.bs_op = BS_STEP;
				st_d      = ST_BS_RD;
			end
			ST_R_CHK: begin
				cmd.vr_cap = 1'b1;
				if (sts.elem_lt_tgt) begin
					cmd.bs_op = BS_ZERO;
					second_d  = 1'b1;
					st_d      = ST_BS_RD;
				end else if (sts.r_nz) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_BELOW;
					st_d       = ST_BELOW_CHK;
				end else begin
					cmd.res_sel = RES_R;
					st_d        = ST_FIN;
				end
			end
			ST_BELOW_CHK: begin
				if (sts.low_wins) begin
					cmd.bs_op = BS_ZERO;
					second_d  = 1'b1;
					st_d      = ST_BS_RD;
				end else begin
					cmd.res_sel = RES_R;
					st_d        = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					st_d         = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// a load beat leaves the controller idle in the next cycle
	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_kind == KIND_LOAD) |=> st_q == ST_IDLE)
		else $error("load beat did not return to idle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_kind == KIND_QUERY) |=> st_q != ST_IDLE)
		else $error("query beat left controller idle");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && sts.out_busy) |=> st_q == ST_FIN)
		else $error("result dropped while output register full");

endmodule
`default_nettype wire

// ===== sv/nvis_dp.sv =====
// datapath: store searched as a sorted array, search registers, comparators and output register
`default_nettype none
module nvis_dp #(
	parameter int STORE_DEPTH = 16384,
	parameter int VALUE_WIDTH = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  nvis_pkg::nvis_in_t                    in_data,
	input  wire                                   cfg_we,
	input  wire  [nvis_pkg::LenWidth-1:0]         cfg_data,
	input  nvis_pkg::nvis_cmd_t                   cmd,
	output nvis_pkg::nvis_sts_t                   sts,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output nvis_pkg::nvis_out_t                   out_data
);
	import nvis_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int PW = $clog2(STORE_DEPTH) + 1;
	localparam int W  = VALUE_WIDTH;

	logic [W-1:0]  store_q [STORE_DEPTH];
	logic [W-1:0]  rdata_q;
	logic [PW-1:0] n_q, probe_q, lo_q, hi_q, r_q, res_q;
	logic [W-1:0]  key_q, tgt_q, vr_q;
	logic          fin_q;
	logic          out_valid_q;
	nvis_out_t     out_q;

	logic [63:0]   in_ext;
	logic [W-1:0]  in_val;
	logic          wr_en;
	logic [AW-1:0] waddr, raddr;
	logic [PW:0]   mid_sum;
	logic [PW-1:0] mid, pc;
	logic [W:0]    d_low, d_high;
	logic [31:0]   res_ext;

	assign in_ext  = {32'b0, in_data.item_value};
	assign in_val  = in_ext[W-1:0];
	assign wr_en   = cmd.accept && in_data.kind == KIND_LOAD &&
		(32'(in_data.element_index) < 32'(STORE_DEPTH));
	assign waddr   = AW'(in_data.element_index);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[PW:1];
	assign pc      = (probe_q >= n_q) ? (n_q - PW'(1)) : probe_q;
	assign d_low   = {key_q[W-1], key_q} - {rdata_q[W-1], rdata_q};
	assign d_high  = {vr_q[W-1], vr_q} - {key_q[W-1], key_q};

	always_comb begin
		case (cmd.rd_sel)
			RD_PROBE: raddr = probe_q[AW-1:0];
			RD_MID:   raddr = mid[AW-1:0];
			RD_HI:    raddr = hi_q[AW-1:0];
			RD_BELOW: raddr = 
				AW'(r_q - PW'(1));
			default:  raddr = hi_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[waddr] <= in_val;
		end
		if (cmd.rd_en) begin
			rdata_q <= store_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			probe_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (32'(cfg_data) > 32'(STORE_DEPTH)) begin
					n_q <= PW'(STORE_DEPTH);
				end else begin
					n_q <= PW'(cfg_data);
				end
			end
			if (cmd.probe_init) begin
				probe_q <= PW'(1);
			end else if (cmd.probe_dbl) begin
				probe_q <= probe_q << 1;
			end
			case (cmd.bs_op)
				BS_PROBE: begin
					lo_q <= pc >> 1;
					hi_q <= pc;
				end
				BS_ZERO: begin
					lo_q <= '0;
					hi_q <= r_q;
				end
				BS_STEP: begin
					if (sts.elem_lt_tgt) begin
						lo_q <= mid + PW'(1);
					end else begin
						hi_q <= mid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= in_val;
			tgt_q <= in_val;
			fin_q <= in_data.final_query;
		end else if (cmd.bs_op == BS_ZERO) begin
			tgt_q <= rdata_q;
		end
		if (cmd.r_cap) begin
			r_q <= hi_q;
		end
		if (cmd.vr_cap) begin
			vr_q <= rdata_q;
		end
		case (cmd.res_sel)
			RES_ZERO: res_q <= '0;
			RES_HI:   res_q <= hi_q;
			RES_R:    res_q <= r_q;
			default: begin
			end
		endcase
	end

	assign res_ext = 32'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.nearest_index <= res_ext[IdxWidth-1:0];
			out_q.batch_last    <= fin_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.n_zero      = (n_q == '0);
	assign sts.probe_lt_n  = (probe_q < n_q);
	assign sts.elem_lt_tgt = ($signed(rdata_q) < $signed(tgt_q));
	assign sts.lo_lt_hi    = (lo_q < hi_q);
	assign sts.r_nz        = (r_q != '0);
	assign sts.low_wins    = (d_low <= d_high);
	assign sts.out_busy    = out_valid_q && out_stall;

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("search range inverted");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for nearest_value_index_search: loads, nearest-value queries and length writes
module tb;
	import nvis_pkg::*;

	localparam int Depth = 16384;
	localparam int LargeLen = 512;
	localparam int QuietLimit = 4000;
	localparam int SettleCycles = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	nvis_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	nvis_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LenWidth-1:0] cfg_data = '0;

	nvis_in_t pending_beats[$];
	nvis_out_t nearest_expected[$];

	logic signed [31:0] store_image[Depth];
	logic signed [31:0] plan_vals[Depth];
	logic [LenWidth-1:0] cur_length = '0;

	int send_gap_max = 16;
	int stall_max = 16;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int items_sent = 0;
	int written_upto = 0;
	int plan_len = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	logic in_acc = 1'b0;
	logic out_acc = 1'b0;
	logic offer_valid;
	nvis_in_t offer;
	nvis_out_t want;
	nvis_out_t answer;

	nearest_value_index_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// first index in [lo, hi) whose element is not below key, else hi
	function automatic logic [LenWidth-1:0] first_not_below(input logic [LenWidth-1:0] lo,
			input logic [LenWidth-1:0] hi, input logic signed [31:0] key);
		logic [LenWidth-1:0] a, b, mid;
		a = lo;
		b = hi;
		while (a < b) begin
			mid = (a + b) >> 1;
			if (!(store_image[mid] < key)) b = mid;
			else a = mid + 1'b1;
		end
		return b;
	endfunction

	function automatic logic [IdxWidth-1:0] predict_nearest(input logic signed [31:0] key);
		logic [LenWidth-1:0] n, probe, r;
		logic signed [31:0] below;
		logic [63:0] d_low, d_high;
		n = cur_length;
		if (n == 0) return '0;
		probe = LenWidth'(1);
		while (probe < n && store_image[probe] < key) probe = probe << 1;
		if (probe >= n) probe = n - 1'b1;
		r = first_not_below(probe >> 1, probe, key);
		if (store_image[r] < key) begin
			r = first_not_below('0, r, store_image[r]);
		end else if (r > 0) begin
			below = store_image[r - 1];
			d_low = longint'(key) - longint'(below);
			d_high = longint'(store_image[r]) - longint'(key);
			if (d_low <= d_high) r = first_not_below('0, r, below);
		end
		return r[IdxWidth-1:0];
	endfunction

	// sender
	always @(negedge clk) begin
		offer_valid = in_valid;
		offer = in_data;
		if (in_valid && in_acc) offer_valid = 1'b0;
		if (!offer_valid) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_beats.size() != 0) begin
				offer = pending_beats.pop_front();
				offer_valid = 1'b1;
				gap_left = $urandom_range(send_gap_max, 0);
			end
		end
		in_valid <= offer_valid;
		in_data <= offer;
	end

	// receiver
	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = 600;
		end
		if (out_acc) stall_left = $urandom_range(stall_max, 0);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// prediction and checking
	always @(posedge clk) begin
		in_acc <= in_valid && !in_stall;
		out_acc <= out_valid && !out_stall;
		if (cfg_valid && cfg_ready) begin
			cur_length = (cfg_data > LenWidth'(Depth)) ? LenWidth'(Depth) : cfg_data;
		end
		if (out_valid && !out_stall) begin
			if (nearest_expected.size() == 0) begin
				$display("%0t unexpected result: expected none, got nearest_index %0d batch_last %0b",
					$time, out_data.nearest_index, out_data.batch_last);
				fail_count++;
			end else begin
				want = nearest_expected.pop_front();
				if (out_data.nearest_index !== want.nearest_index) begin
					$display("%0t nearest_index mismatch: expected %0d, got %0d",
						$time, want.nearest_index, out_data.nearest_index);
					fail_count++;
				end
				if (out_data.batch_last !== want.batch_last) begin
					$display("%0t batch_last mismatch: expected %0b, got %0b",
						$time, want.batch_last, out_data.batch_last);
					fail_count++;
				end
			end
		end
		if (in_valid && !in_stall) begin
			if (in_data.kind == KIND_LOAD) begin
				store_image[in_data.element_index] = in_data.item_value;
			end else begin
				answer.nearest_index = predict_nearest(in_data.item_value);
				answer.batch_last = in_data.final_query;
				nearest_expected.push_back(answer);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QuietLimit) begin
			$display("[nearest_value_index_search] ERROR");
			$finish;
		end
	end

	task automatic push_load(input int idx, input logic [31:0] val);
		nvis_in_t b;
		b.kind = KIND_LOAD;
		b.element_index = idx[IdxWidth-1:0];
		b.item_value = val;
		b.final_query = 1'($urandom_range(1, 0));
		plan_vals[idx] = val;
		pending_beats.push_back(b);
		items_sent++;
	endtask

	task automatic push_query(input logic [31:0] key, input logic fin);
		nvis_in_t b;
		b.kind = KIND_QUERY;
		b.element_index = IdxWidth'($urandom_range(Depth - 1, 0));
		b.item_value = key;
		b.final_query = fin;
		pending_beats.push_back(b);
		items_sent++;
	endtask

	task automatic settle();
		while (pending_beats.size() != 0 || in_valid || nearest_expected.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_length(input int len);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len[LenWidth-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		plan_len = (len[LenWidth-1:0] > Depth) ? Depth : len[LenWidth-1:0];
	endtask

	// non-descending run from index 0, or random words when jumbled
	task automatic load_block(input int count, input int step_max, input bit jumbled);
		longint v, span;
		v = longint'($signed($urandom));
		span = longint'(count) * step_max;
		if (v + span > 64'sd2147483647) v = 64'sd2147483647 - span;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		for (int i = 0; i < count; i++) begin
			push_load(i, jumbled ? $urandom : v[31:0]);
			v = v + $urandom_range(step_max, 0);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
		end
		if (count > written_upto) written_upto = count;
	endtask

	function automatic int pick_step();
		case ($urandom_range(7, 0))
			0: return 0;
			1: return 1;
			2: return 3;
			3: return 1000;
			4: return 1 << 20;
			5: return 1 << 27;
			default: return 50;
		endcase
	endfunction

	function automatic logic [31:0] pick_key(input int n);
		int i;
		longint m;
		if (n == 0) return $urandom;
		i = $urandom_range(n - 1, 0);
		case ($urandom_range(9, 0))
			0: return plan_vals[i];
			1: return plan_vals[i] + 1;
			2: return plan_vals[i] - 1;
			3: begin
				if (n < 2) return plan_vals[0];
				if (i == n - 1) i = n - 2;
				m = (longint'(plan_vals[i]) + longint'(plan_vals[i + 1])) >>> 1;
				return m[31:0] + $urandom_range(1, 0);
			end
			4: return 32'h8000_0000;
			5: return 32'h7fff_ffff;
			6: return plan_vals[0] - $urandom_range(100, 1);
			7: return plan_vals[n - 1] + $urandom_range(100, 1);
			default: return $urandom;
		endcase
	endfunction

	function automatic int small_length();
		case ($urandom_range(19, 0))
			0: return 0;
			1: return 1;
			2: return 2;
			3, 4, 5, 6: return $urandom_range(200, 17);
			default: return $urandom_range(16, 1);
		endcase
	endfunction

	task automatic random_phase(input int length, input int queries, input bit reload,
			input bit jumbled);
		settle();
		case ($urandom_range(3, 0))
			0: begin send_gap_max = 0; stall_max = 0; end
			1: begin send_gap_max = 0; stall_max = 16; end
			2: begin send_gap_max = 16; stall_max = 0; end
			default: begin send_gap_max = 16; stall_max = 16; end
		endcase
		write_length(length);
		if (reload || plan_len > written_upto) load_block(plan_len, pick_step(), jumbled);
		for (int q = 0; q < queries; q++) begin
			if ($urandom_range(15, 0) == 0) push_load($urandom_range(Depth - 1, 0), $urandom);
			push_query(pick_key(plan_len), 1'($urandom_range(1, 0)));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty array
		push_query(32'h8000_0000, 1'b0);
		push_query(32'h7fff_ffff, 1'b1);
		push_load(Depth - 1, 32'h7fff_ffff);
		push_load(0, 32'h8000_0000);
		push_load(1, -32'sd100);
		push_load(2, -32'sd100);
		push_load(3, 32'd0);
		push_load(4, 32'd10);
		push_load(5, 32'd20);
		push_load(6, 32'd2147483646);
		push_load(7, 32'd2147483646);
		written_upto = 8;
		settle();
		write_length(8);
		push_query(32'h8000_0000, 1'b0);
		push_query(-32'sd100, 1'b1);
		push_query(32'd5, 1'b0);
		push_query(32'd15, 1'b1);
		push_query(32'd20, 1'b0);
		push_query(32'h7fff_ffff, 1'b1);
		push_query(32'd1073741823, 1'b0);
		push_query(-32'sd1073741874, 1'b1);
		push_query(32'd2147483646, 1'b0);
		push_query(-32'sd101, 1'b1);
		settle();
		write_length(1);
		push_query(32'h7fff_ffff, 1'b0);
		push_query(32'h8000_0000, 1'b1);

		while (items_sent < 400)
			random_phase(small_length(), $urandom_range(40, 10), 1'($urandom_range(1, 0)),
				$urandom_range(7, 0) == 0);

		// output held off while queries keep coming
		settle();
		send_gap_max = 0;
		stall_max = 16;
		hold_requests++;
		repeat (30) push_query(pick_key(plan_len), 1'($urandom_range(1, 0)));

		// large store
		settle();
		send_gap_max = 0;
		stall_max = 0;
		write_length(LargeLen);
		load_block(LargeLen, 100000, 1'b0);
		repeat (20) push_query(pick_key(plan_len), 1'($urandom_range(1, 0)));

		// saturated length, keys low enough that only the loaded run is probed
		settle();
		write_length(Depth + 1 + $urandom_range(16382, 0));
		repeat (20)
			push_query(plan_vals[$urandom_range(LargeLen / 2, 0)], 1'($urandom_range(1, 0)));
		random_phase(LargeLen - 1, 20, 1'b0, 1'b0);
		random_phase($urandom_range(LargeLen - 2, LargeLen / 2), 20, 1'b0, 1'b0);
		random_phase($urandom_range(LargeLen / 2, 17), 20, 1'b0, 1'b0);

		while (items_sent < 1250)
			random_phase(small_length(), $urandom_range(40, 10), 1'($urandom_range(1, 0)),
				$urandom_range(7, 0) == 0);

		settle();
		if (fail_count == 0)
			$display("[nearest_value_index_search] OK");
		else
			$display("[nearest_value_index_search] ERROR");
		$finish;
	end

endmodule

// ===== nearest_value_index_search.f =====
sv/nvis_pkg.sv
sv/nvis_ctrl.sv
sv/nvis_dp.sv
sv/nearest_value_index_search.sv
sim/tb.sv
